FILE: hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Slack beyond the header a leftover must exceed before a split
  localparam int unsigned SPLIT_SLACK = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  // Command broadcast to every cell of the table
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_START,
    CMD_SCAN,
    CMD_TAKE,
    CMD_SPLIT,
    CMD_FREE,
    CMD_FREE_MERGE,
    CMD_MERGE_PREV
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      op;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator built from a chain of table cells.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, op_i, req_size_i, free_addr_i | in
//  out     | out_valid_o/out_ready_i, status_o, addr_o,        | out
//          | allocated_bytes_o                                |
//
// A request holds the block from accept to response: the search probe walks the
// cell chain one entry per cycle until it hits or misses, then the update is
// applied, with an extra merge step for a free whose lower neighbor is free.
// A zero-size allocate skips the search. Reset loads the single free block at
// once, no sweep. A stalled output holds the finished request in its response
// state.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire          op_i,
  input  wire  [15:0]  req_size_i,
  input  wire  [15:0]  free_addr_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [1:0]   status_o,
  output logic [15:0]  addr_o,
  output logic [16:0]  allocated_bytes_o
);

  localparam int unsigned AW = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned W  = ((AW > 17) ? AW : 17) + 2;
  localparam int unsigned N  = MAX_BLOCKS;
  localparam logic [W-1:0] HdrW   = W'(HEADER_BYTES);
  localparam logic [W-1:0] SlackW = W'(ffha_pkg::SPLIT_SLACK);
  localparam logic [W-1:0] InitSz = W'(HEAP_BYTES - HEADER_BYTES);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_MERGE, S_RESP} state_e;

  state_e state_q;
  logic   op_q;
  logic [W-1:0] rsize_q, total_q, hstart_q, hsize_q;
  logic [15:0]  faddr_q;
  logic         hprev_q;
  logic         c_free_next_q;
  logic [1:0]   res_status_q;
  logic [15:0]  res_addr_q;
  logic         out_valid_q;
  logic [1:0]   status_q;
  logic [15:0]  addr_q;
  logic [16:0]  alloc_q;

  ffha_pkg::cell_ctrl_t ctrl;

  logic [W-1:0] c_start [N];
  logic [W-1:0] c_size  [N];
  logic [N-1:0] c_free, c_valid, c_hit, c_probe, c_miss;

  // Chain of cells, neighbors wired directly
  for (genvar k = 0; k < N; k++) begin : g_cell
    ffha_cell #(
      .W(W), .HDR(HEADER_BYTES),
      .RST_VALID(k == 0), .RST_SIZE((k == 0) ? InitSz : '0)
    ) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i      (ctrl),
      .rsize_i     (rsize_q),
      .faddr_i     (faddr_q),
      .seed_i      (k == 0),
      .probe_i     ((k == 0) ? 1'b0 : c_probe[(k == 0) ? 0 : k-1]),
      .prev_start_i((k == 0) ? '0 : c_start[(k == 0) ? 0 : k-1]),
      .prev_size_i ((k == 0) ? '0 : c_size[(k == 0) ? 0 : k-1]),
      .prev_free_i ((k == 0) ? 1'b0 : c_free[(k == 0) ? 0 : k-1]),
      .prev_valid_i((k == 0) ? 1'b0 : c_valid[(k == 0) ? 0 : k-1]),
      .prev_hit_i  ((k == 0) ? 1'b0 : c_hit[(k == 0) ? 0 : k-1]),
      .next_start_i((k == N-1) ? '0 : c_start[(k == N-1) ? k : k+1]),
      .next_size_i ((k == N-1) ? '0 : c_size[(k == N-1) ? k : k+1]),
      .next_free_i ((k == N-1) ? 1'b0 : c_free[(k == N-1) ? k : k+1]),
      .next_valid_i((k == N-1) ? 1'b0 : c_valid[(k == N-1) ? k : k+1]),
      .next_hit_i  ((k == N-1) ? 1'b0 : c_hit[(k == N-1) ? k : k+1]),
      .start_o     (c_start[k]),
      .size_o      (c_size[k]),
      .free_o      (c_free[k]),
      .valid_o     (c_valid[k]),
      .hit_o       (c_hit[k]),
      .probe_o     (c_probe[k]),
      .miss_o      (c_miss[k])
    );
  end

  // Pick out the hit entry and its neighbors' free marks (hit is one-hot)
  logic [W-1:0] h_start, h_size;
  logic         h_prev, h_next, any_hit, any_miss;
  always_comb begin
    h_start = '0;
    h_size  = '0;
    h_prev  = 1'b0;
    h_next  = 1'b0;
    for (int k = 0; k < N; k++) begin
      h_start = h_start | (c_start[k] & {W{c_hit[k]}});
      h_size  = h_size  | (c_size[k]  & {W{c_hit[k]}});
      if (k > 0)   h_prev = h_prev | (c_hit[k] & c_free[k-1] & c_valid[k-1]);
      if (k < N-1) h_next = h_next | (c_hit[k] & c_free[k+1] & c_valid[k+1]);
    end
    any_hit  = |c_hit;
    any_miss = (|c_miss) | c_probe[N-1];
  end

  logic split;
  assign split = (hsize_q > rsize_q + HdrW + SlackW) && !c_valid[N-1];

  // Command to the cells
  always_comb begin
    ctrl.op  = op_q;
    ctrl.cmd = ffha_pkg::CMD_HOLD;
    unique case (state_q)
      S_IDLE:  ctrl.cmd = (in_valid_i && (op_i || (req_size_i != '0)))
                          ? ffha_pkg::CMD_START : ffha_pkg::CMD_HOLD;
      S_SCAN:  ctrl.cmd = ffha_pkg::CMD_SCAN;
      S_APPLY: begin
        if (op_q == ffha_pkg::OP_ALLOC) begin
          ctrl.cmd = split ? ffha_pkg::CMD_SPLIT : ffha_pkg::CMD_TAKE;
        end else begin
          ctrl.cmd = c_free_next_q ? ffha_pkg::CMD_FREE_MERGE : ffha_pkg::CMD_FREE;
        end
      end
      S_MERGE: ctrl.cmd = ffha_pkg::CMD_MERGE_PREV;
      S_RESP:  ctrl.cmd = ffha_pkg::CMD_HOLD;
      default: ctrl.cmd = ffha_pkg::CMD_HOLD;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
      op_q          <= ffha_pkg::OP_ALLOC;
      c_free_next_q <= 1'b0;
      hprev_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_i;
            faddr_q <= free_addr_i;
            rsize_q <= (W'(req_size_i) + W'(3)) & ~W'(3);
            if (op_i == ffha_pkg::OP_ALLOC && req_size_i == '0) begin
              res_status_q <= ffha_pkg::ST_NOMEM;
              res_addr_q   <= '0;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            hstart_q      <= h_start;
            hsize_q       <= h_size;
            hprev_q       <= h_prev;
            c_free_next_q <= h_next;
            state_q       <= S_APPLY;
          end else if (any_miss) begin
            res_status_q <= (op_q == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NOMEM
                                                         : ffha_pkg::ST_BAD_FREE;
            res_addr_q   <= '0;
            state_q      <= S_RESP;
          end
        end
        S_APPLY: begin
          res_status_q <= ffha_pkg::ST_OK;
          if (op_q == ffha_pkg::OP_ALLOC) begin
            total_q    <= total_q + (split ? rsize_q : hsize_q);
            res_addr_q <= 16'(hstart_q + HdrW);
            state_q    <= S_RESP;
          end else begin
            total_q    <= total_q - hsize_q;
            res_addr_q <= '0;
            state_q    <= hprev_q ? S_MERGE : S_RESP;
          end
        end
        S_MERGE: state_q <= S_RESP;
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            addr_q      <= res_addr_q;
            alloc_q     <= total_q[16:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign addr_o            = addr_q;
  assign allocated_bytes_o = alloc_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ffha_cell.sv
// One table entry of the allocator: holds a block and its scan flags.
`default_nettype none
module ffha_cell #(
  parameter int unsigned W          = 20,
  parameter int unsigned HDR        = 12,
  parameter logic        RST_VALID  = 1'b0,
  parameter logic [W-1:0] RST_SIZE  = '0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ffha_pkg::cell_ctrl_t ctrl_i,
  input  wire  [W-1:0]        rsize_i,
  input  wire  [15:0]         faddr_i,
  input  wire                 seed_i,
  input  wire                 probe_i,
  input  wire  [W-1:0]        prev_start_i,
  input  wire  [W-1:0]        prev_size_i,
  input  wire                 prev_free_i,
  input  wire                 prev_valid_i,
  input  wire                 prev_hit_i,
  input  wire  [W-1:0]        next_start_i,
  input  wire  [W-1:0]        next_size_i,
  input  wire                 next_free_i,
  input  wire                 next_valid_i,
  input  wire                 next_hit_i,
  output logic [W-1:0]        start_o,
  output logic [W-1:0]        size_o,
  output logic                free_o,
  output logic                valid_o,
  output logic                hit_o,
  output logic                probe_o,
  output logic                miss_o
);

  localparam logic [W-1:0] HdrW = W'(HDR);

  logic [W-1:0] start_q, start_d, size_q, size_d;
  logic         free_q, free_d, valid_q, valid_d;
  logic         probe_q, probe_d, passed_q, passed_d, hit_q, hit_d;
  logic         match;

  // Local fit / address test against the broadcast request
  always_comb begin
    if (ctrl_i.op == ffha_pkg::OP_ALLOC) begin
      match = free_q && (size_q >= rsize_i);
    end else begin
      match = !free_q && ((start_q + HdrW) == {{(W-16){1'b0}}, faddr_i});
    end
  end

  assign probe_o = probe_q & valid_q & ~match;
  assign miss_o  = probe_q & ~valid_q;
  assign start_o = start_q;
  assign size_o  = size_q;
  assign free_o  = free_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

  // Per-command update; "not passed" means the cell lies after the hit
  always_comb begin
    start_d  = start_q;
    size_d   = size_q;
    free_d   = free_q;
    valid_d  = valid_q;
    probe_d  = 1'b0;
    passed_d = passed_q;
    hit_d    = hit_q;
    unique case (ctrl_i.cmd)
      ffha_pkg::CMD_HOLD: begin
      end
      ffha_pkg::CMD_START: begin
        probe_d  = seed_i;
        passed_d = 1'b0;
        hit_d    = 1'b0;
      end
      ffha_pkg::CMD_SCAN: begin
        probe_d  = probe_i;
        passed_d = passed_q | probe_q;
        hit_d    = hit_q | (probe_q & valid_q & match);
      end
      ffha_pkg::CMD_TAKE: begin
        if (hit_q) free_d = 1'b0;
      end
      ffha_pkg::CMD_SPLIT: begin
        if (hit_q) begin
          free_d = 1'b0;
          size_d = rsize_i;
        end else if (!passed_q && prev_hit_i) begin
          start_d = prev_start_i + HdrW + rsize_i;
          size_d  = prev_size_i - rsize_i - HdrW;
          free_d  = 1'b1;
          valid_d = 1'b1;
        end else if (!passed_q) begin
          start_d = prev_start_i;
          size_d  = prev_size_i;
          free_d  = prev_free_i;
          valid_d = prev_valid_i;
        end
      end
      ffha_pkg::CMD_FREE: begin
        if (hit_q) free_d = 1'b1;
      end
      ffha_pkg::CMD_FREE_MERGE: begin
        if (hit_q) begin
          free_d = 1'b1;
          size_d = size_q + HdrW + next_size_i;
        end else if (!passed_q) begin
          start_d = next_start_i;
          size_d  = next_size_i;
          free_d  = next_free_i;
          valid_d = next_valid_i;
        end
      end
      ffha_pkg::CMD_MERGE_PREV: begin
        if (next_hit_i) begin
          size_d = size_q + HdrW + next_size_i;
        end else if (hit_q || !passed_q) begin
          start_d = next_start_i;
          size_d  = next_size_i;
          free_d  = next_free_i;
          valid_d = next_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      size_q   <= RST_SIZE;
      free_q   <= RST_VALID;
      valid_q  <= RST_VALID;
      probe_q  <= 1'b0;
      passed_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      start_q  <= start_d;
      size_q   <= size_d;
      free_q   <= free_d;
      valid_q  <= valid_d;
      probe_q  <= probe_d;
      passed_q <= passed_d;
      hit_q    <= hit_d;
    end
  end

endmodule
`default_nettype wire

FILE: test/first_fit_heap_allocator_tb.sv
// Testbench for the first-fit heap allocator: directed and random requests checked against a model.
`default_nettype none
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP   = 65536;
  localparam int unsigned NBLK   = 64;
  localparam int unsigned HDR    = 12;
  localparam int unsigned WD_MAX = 20000;

  typedef struct {
    ffha_pkg::status_e status;
    logic [15:0]       addr;
    logic [16:0]       total;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        op_i = ffha_pkg::OP_ALLOC;
  logic [15:0] req_size_i = '0;
  logic [15:0] free_addr_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o, out_valid_o;
  logic [1:0]  status_o;
  logic [15:0] addr_o;
  logic [16:0] allocated_bytes_o;

  first_fit_heap_allocator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .req_size_i, .free_addr_i,
    .out_valid_o, .out_ready_i, .status_o, .addr_o, .allocated_bytes_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Heap model state
  int unsigned   blk_start [NBLK];
  int unsigned   blk_size  [NBLK];
  bit            blk_free  [NBLK];
  int unsigned   blk_count;
  int unsigned   bytes_in_use;
  alloc_result_t pending_results[$];
  logic [15:0]   live_addrs[$];

  int unsigned errors = 0;
  int unsigned sent = 0, checked = 0, n_ok = 0, n_nomem = 0, n_bad = 0, n_split_full = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit          recv_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic void heap_reset();
    for (int i = 0; i < NBLK; i++) begin
      blk_start[i] = 0; blk_size[i] = 0; blk_free[i] = 1'b0;
    end
    blk_size[0] = HEAP - HDR;
    blk_free[0] = 1'b1;
    blk_count = 1;
    bytes_in_use = 0;
  endfunction

  function automatic void remove_block(int unsigned k);
    for (int unsigned j = k; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1]; blk_size[j] = blk_size[j+1]; blk_free[j] = blk_free[j+1];
    end
    blk_count--;
    blk_start[blk_count] = 0; blk_size[blk_count] = 0; blk_free[blk_count] = 1'b0;
  endfunction

  // Apply one request to the model and return the expected response
  function automatic alloc_result_t heap_apply(logic op, logic [15:0] sz, logic [15:0] fa);
    alloc_result_t r;
    int unsigned   rs, i;
    r.status = ffha_pkg::ST_OK; r.addr = '0;
    if (op == ffha_pkg::OP_ALLOC) begin
      r.status = ffha_pkg::ST_NOMEM;
      if (sz != 0) begin
        rs = (int'(sz) + 3) & ~3;
        for (i = 0; i < blk_count; i++) begin
          if (blk_free[i] && blk_size[i] >= rs) begin
            blk_free[i] = 1'b0;
            if (blk_size[i] > rs + HDR + ffha_pkg::SPLIT_SLACK) begin
              if (blk_count < NBLK) begin
                for (int unsigned j = blk_count; j > i + 1; j--) begin
                  blk_start[j] = blk_start[j-1]; blk_size[j] = blk_size[j-1];
                  blk_free[j] = blk_free[j-1];
                end
                blk_count++;
                blk_start[i+1] = blk_start[i] + HDR + rs;
                blk_size[i+1]  = blk_size[i] - rs - HDR;
                blk_free[i+1]  = 1'b1;
                blk_size[i]    = rs;
              end else n_split_full++;
            end
            bytes_in_use += blk_size[i];
            r.status = ffha_pkg::ST_OK;
            r.addr = 16'(blk_start[i] + HDR);
            break;
          end
        end
      end
    end else begin
      for (i = 0; i < blk_count; i++)
        if (!blk_free[i] && blk_start[i] + HDR == fa) break;
      if (i >= blk_count) r.status = ffha_pkg::ST_BAD_FREE;
      else begin
        blk_free[i] = 1'b1;
        bytes_in_use -= blk_size[i];
        if (i + 1 < blk_count && blk_free[i+1]) begin
          blk_size[i] += HDR + blk_size[i+1];
          remove_block(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
          blk_size[i-1] += HDR + blk_size[i];
          remove_block(i);
        end
      end
    end
    r.total = 17'(bytes_in_use);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("MISMATCH result %0d: %s got %0d expected %0d", checked, what, got, want);
  endtask

  // Send one transaction, with random idle cycles before it
  task automatic send_request(logic op, logic [15:0] sz, logic [15:0] fa);
    alloc_result_t r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1; op_i = op; req_size_i = sz; free_addr_i = fa;
    do @(posedge clk_i); while (!in_ready_o);
    r = heap_apply(op, sz, fa);
    pending_results.push_back(r);
    if (op == ffha_pkg::OP_ALLOC && r.status == ffha_pkg::ST_OK) live_addrs.push_back(r.addr);
    if (op == ffha_pkg::OP_FREE && r.status == ffha_pkg::ST_OK)
      foreach (live_addrs[k]) if (live_addrs[k] == fa) begin
        live_addrs.delete(k);
        break;
      end
    sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver ready pattern
  always @(negedge clk_i)
    if (rst_ni) out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

  // Response checker
  always @(posedge clk_i) begin
    alloc_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("MISMATCH: response with nothing outstanding");
      end else begin
        w = pending_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (addr_o !== w.addr) report_mismatch("addr", addr_o, w.addr);
        if (allocated_bytes_o !== w.total)
          report_mismatch("allocated_bytes", allocated_bytes_o, w.total);
        case (w.status)
          ffha_pkg::ST_OK:    n_ok++;
          ffha_pkg::ST_NOMEM: n_nomem++;
          default:            n_bad++;
        endcase
      end
      checked++;
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || recv_hold) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_MAX) begin
      $display("Watchdog expired");
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_live();
    if (live_addrs.size() == 0) return 16'd12;
    return live_addrs[$urandom_range(live_addrs.size() - 1)];
  endfunction

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [15:0] a;
    send_request(ffha_pkg::OP_ALLOC, 16'd0, 16'd0);          // zero size
    send_request(ffha_pkg::OP_FREE, 16'd0, 16'd0);           // offset zero
    send_request(ffha_pkg::OP_ALLOC, 16'd1, 16'hFFFF);
    a = pick_live();
    send_request(ffha_pkg::OP_FREE, 16'd0, a);
    send_request(ffha_pkg::OP_FREE, 16'hFFFF, a);            // double free
    send_request(ffha_pkg::OP_ALLOC, 16'hFFFF, 16'd0);       // out of memory
    send_request(ffha_pkg::OP_ALLOC, 16'd65524, 16'd0);      // whole heap
    send_request(ffha_pkg::OP_ALLOC, 16'd4, 16'd0);          // nothing left
    send_request(ffha_pkg::OP_FREE, 16'd0, 16'd12);
    send_request(ffha_pkg::OP_ALLOC, 16'd100, 16'd0);
    send_request(ffha_pkg::OP_ALLOC, 16'd110, 16'd0);        // splits the remaining free block
    send_request(ffha_pkg::OP_ALLOC, 16'd3, 16'd0);
    send_request(ffha_pkg::OP_FREE, 16'd0, 16'd13);          // misaligned, unknown
    send_request(ffha_pkg::OP_FREE, 16'd0, 16'd12);
    send_request(ffha_pkg::OP_FREE, 16'd0, pick_live());
    send_request(ffha_pkg::OP_FREE, 16'd0, pick_live());
    send_request(ffha_pkg::OP_FREE, 16'd0, pick_live());
    send_request(ffha_pkg::OP_ALLOC, 16'h5555, 16'hAAAA);
    send_request(ffha_pkg::OP_FREE, 16'hAAAA, 16'h5555);
  endtask

  // Fill the table so splits are refused, then release everything
  task automatic test_table_full();
    repeat (70) send_request(ffha_pkg::OP_ALLOC, 16'($urandom_range(1, 40)), 16'($urandom));
    send_request(ffha_pkg::OP_ALLOC, 16'd900, 16'd0);
    while (live_addrs.size() != 0) send_request(ffha_pkg::OP_FREE, 16'($urandom), pick_live());
  endtask

  task automatic test_random(int unsigned n);
    int unsigned sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 45 || live_addrs.size() == 0)
        send_request(ffha_pkg::OP_ALLOC,
                     (sel < 5) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                     16'($urandom));
      else if (sel < 90) send_request(ffha_pkg::OP_FREE, 16'($urandom), pick_live());
      else send_request(ffha_pkg::OP_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        int unsigned c;
        for (c = 0; c < 600; c++) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(10);
    join
  endtask

  initial begin
    heap_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    send_idle_pct = 38; recv_idle_pct = 53;
    test_random(450);
    send_idle_pct = 53; recv_idle_pct = 38;
    test_random(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(350);
    drain();
    repeat (100) @(negedge clk_i);
    $display("Covered %0d requests: %0d ok, %0d out of memory or zero, %0d bad free",
             sent, n_ok, n_nomem, n_bad);
    $display("Splits refused with a full table: %0d; mismatches: %0d", n_split_full, errors);
    if (errors == 0 && pending_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
